### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the update chunk guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge except while reset is high.
`define FUCG_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FUCG_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/fucg_pkg.sv
// ----------------------------------------------------------------------------
// fucg_pkg
// Types, codes and defaults shared by the update chunk guard modules.
// ----------------------------------------------------------------------------
package fucg_pkg;

   localparam int HEADER_BYTES_DEFAULT   = 1024;
   localparam int TRANSFER_BYTES_DEFAULT = 1024;
   localparam int QUEUE_DEPTH_DEFAULT    = 4;
   localparam int RESULT_DEPTH_DEFAULT   = 4;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REG_INDEX_WIDTH = 3;

   localparam logic [23:0] BACKOFF_RESET = 24'd60000;

   // Register indexes.
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RO_BASE   = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RO_TOP    = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RW_BASE   = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_RW_TOP    = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_BACKOFF   = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_HARD_BOOT = 3'd5;

   localparam logic KIND_CHUNK = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   localparam logic [1:0] OUTCOME_OK          = 2'd0;
   localparam logic [1:0] OUTCOME_ERASE_FAIL  = 2'd1;
   localparam logic [1:0] OUTCOME_WRITE_FAIL  = 2'd2;
   localparam logic [1:0] OUTCOME_VERIFY_FAIL = 2'd3;

   localparam logic [3:0] STATUS_OK        = 4'd0;
   localparam logic [3:0] STATUS_DATA      = 4'd1;
   localparam logic [3:0] STATUS_OVERLAP   = 4'd2;
   localparam logic [3:0] STATUS_TRUNCATED = 4'd3;
   localparam logic [3:0] STATUS_ROLLBACK  = 4'd4;
   localparam logic [3:0] STATUS_BOARD     = 4'd5;
   localparam logic [3:0] STATUS_ADDRESS   = 4'd6;
   localparam logic [3:0] STATUS_ERASE     = 4'd7;
   localparam logic [3:0] STATUS_RATE      = 4'd8;
   localparam logic [3:0] STATUS_WRITE     = 4'd9;
   localparam logic [3:0] STATUS_VERIFY    = 4'd10;

   localparam logic [1:0] ERASE_NONE = 2'd0;
   localparam logic [1:0] ERASE_RO   = 2'd1;
   localparam logic [1:0] ERASE_RW   = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [23:0] dest_offset;
      logic [15:0] payload_len;
      logic        digest_ok;
      logic [31:0] new_epoch;
      logic [31:0] new_major;
      logic [31:0] new_minor;
      logic [31:0] old_epoch;
      logic [31:0] old_major;
      logic [31:0] old_minor;
      logic        board_reject;
      logic [1:0]  flash_outcome;
   } req_type;

   typedef struct packed {
      logic [3:0] status;
      logic [1:0] erase_section;
      logic       mark_header;
      logic       write_done;
   } rsp_type;

   typedef struct packed {
      logic [23:0] ro_base;
      logic [23:0] ro_top;
      logic [23:0] rw_base;
      logic [23:0] rw_top;
      logic [23:0] backoff_ticks;
      logic        hard_reset_boot;
   } cfg_type;

   // A classified word handed from the front part to the back part.
   typedef struct packed {
      logic        is_tick;
      logic [3:0]  pre_status;
      logic [1:0]  erase_section;
      logic        at_base;
      logic        in_rw_rate;
      logic [23:0] dest_offset;
      logic [1:0]  flash_outcome;
   } entry_type;

endpackage

### sv/fucg_queue.sv
// ----------------------------------------------------------------------------
// fucg_queue
// Small register FIFO with count-based full and empty flags.
// ----------------------------------------------------------------------------
module fucg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/fucg_csr.sv
// ----------------------------------------------------------------------------
// fucg_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module fucg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fucg_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [fucg_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [fucg_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output fucg_pkg::cfg_type                   cfg
);

   fucg_pkg::cfg_type                          cfg_ff, cfg_in;
   logic [fucg_pkg::REG_INDEX_WIDTH-1:0]       index;
   logic                                       wr_en;

   assign pready = 1'b1;
   assign index  = paddr[fucg_pkg::CSR_ADDR_WIDTH-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            fucg_pkg::REG_RO_BASE:   cfg_in.ro_base         = pwdata[23:0];
            fucg_pkg::REG_RO_TOP:    cfg_in.ro_top          = pwdata[23:0];
            fucg_pkg::REG_RW_BASE:   cfg_in.rw_base         = pwdata[23:0];
            fucg_pkg::REG_RW_TOP:    cfg_in.rw_top          = pwdata[23:0];
            fucg_pkg::REG_BACKOFF:   cfg_in.backoff_ticks   = pwdata[23:0];
            fucg_pkg::REG_HARD_BOOT: cfg_in.hard_reset_boot = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         fucg_pkg::REG_RO_BASE:   prdata = {8'd0, cfg_ff.ro_base};
         fucg_pkg::REG_RO_TOP:    prdata = {8'd0, cfg_ff.ro_top};
         fucg_pkg::REG_RW_BASE:   prdata = {8'd0, cfg_ff.rw_base};
         fucg_pkg::REG_RW_TOP:    prdata = {8'd0, cfg_ff.rw_top};
         fucg_pkg::REG_BACKOFF:   prdata = {8'd0, cfg_ff.backoff_ticks};
         fucg_pkg::REG_HARD_BOOT: prdata = {31'd0, cfg_ff.hard_reset_boot};
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ro_base         <= '0;
         cfg_ff.ro_top          <= '0;
         cfg_ff.rw_base         <= '0;
         cfg_ff.rw_top          <= '0;
         cfg_ff.backoff_ticks   <= fucg_pkg::BACKOFF_RESET;
         cfg_ff.hard_reset_boot <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/fucg_front.sv
// ----------------------------------------------------------------------------
// fucg_front
// Classifies an incoming word: digest, header, rollback, board, range and
// erase checks, none of which depend on the rate-limit state.
// ----------------------------------------------------------------------------
module fucg_front #(
   parameter int HEADER_BYTES = fucg_pkg::HEADER_BYTES_DEFAULT
) (
   input  fucg_pkg::req_type   req,
   input  fucg_pkg::cfg_type   cfg,
   output fucg_pkg::entry_type entry
);

   localparam logic [24:0] HDR = 25'(HEADER_BYTES);

   logic [23:0] off;
   logic [24:0] off_w, end_w, size_w;
   logic [24:0] ro_base_w, rw_base_w, ro_top_w, rw_top_w;
   logic        ro_at, rw_at, at_base;
   logic        older, overlap, rw_range, ro_range;

   // True when pos falls inside the header area that starts at base.
   function automatic logic hits_header(input logic [24:0] pos, input logic [24:0] base);
      return (pos >= base) && (pos < base + HDR);
   endfunction

   assign off       = req.dest_offset;
   assign off_w     = {1'b0, off};
   assign size_w    = {9'd0, req.payload_len};
   assign end_w     = off_w + size_w;
   assign ro_base_w = {1'b0, cfg.ro_base};
   assign rw_base_w = {1'b0, cfg.rw_base};
   assign ro_top_w  = {1'b0, cfg.ro_top};
   assign rw_top_w  = {1'b0, cfg.rw_top};

   assign ro_at   = (off == cfg.ro_base);
   assign rw_at   = (off == cfg.rw_base);
   assign at_base = ro_at || rw_at;

   assign older = (req.new_epoch != req.old_epoch) ? (req.new_epoch < req.old_epoch) :
                  (req.new_major != req.old_major) ? (req.new_major < req.old_major) :
                  (req.new_minor < req.old_minor);

   assign overlap = hits_header(off_w, ro_base_w) || hits_header(end_w, ro_base_w) ||
                    hits_header(off_w, rw_base_w) || hits_header(end_w, rw_base_w);

   assign rw_range = (cfg.rw_top != '0) && (off >= cfg.rw_base) && (end_w <= rw_top_w);
   assign ro_range = (cfg.ro_top != '0) && (off >= cfg.ro_base) && (end_w <= ro_top_w);

   always_comb begin
      entry.is_tick       = (req.kind == fucg_pkg::KIND_TICK);
      entry.at_base       = at_base;
      entry.in_rw_rate    = (off >= cfg.rw_base) && (off < cfg.rw_top);
      entry.dest_offset   = off;
      entry.flash_outcome = req.flash_outcome;
      entry.erase_section = fucg_pkg::ERASE_NONE;
      entry.pre_status    = fucg_pkg::STATUS_OK;
      if (!req.digest_ok) begin
         entry.pre_status = fucg_pkg::STATUS_DATA;
      end else if (at_base && (size_w < HDR)) begin
         entry.pre_status = fucg_pkg::STATUS_TRUNCATED;
      end else if (at_base && older) begin
         entry.pre_status = fucg_pkg::STATUS_ROLLBACK;
      end else if (at_base && !ro_at && req.board_reject) begin
         // Only a read-write header carries a board identity.
         entry.pre_status = fucg_pkg::STATUS_BOARD;
      end else if (!at_base && overlap) begin
         entry.pre_status = fucg_pkg::STATUS_OVERLAP;
      end else if (rw_range) begin
         if (rw_at) begin
            entry.erase_section = fucg_pkg::ERASE_RW;
            if (req.flash_outcome == fucg_pkg::OUTCOME_ERASE_FAIL) begin
               entry.pre_status = fucg_pkg::STATUS_ERASE;
            end
         end
      end else if (ro_range) begin
         if (ro_at) begin
            entry.erase_section = fucg_pkg::ERASE_RO;
            if (req.flash_outcome == fucg_pkg::OUTCOME_ERASE_FAIL) begin
               entry.pre_status = fucg_pkg::STATUS_ERASE;
            end
         end
      end else begin
         entry.pre_status = fucg_pkg::STATUS_ADDRESS;
      end
   end

endmodule

### sv/fucg_back.sv
// ----------------------------------------------------------------------------
// fucg_back
// Applies the rate limit, keeps the tick counter and the last written offsets,
// and produces one result word per chunk.
// ----------------------------------------------------------------------------
module fucg_back #(
   parameter int TRANSFER_BYTES = fucg_pkg::TRANSFER_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  fucg_pkg::cfg_type   cfg,
   input  fucg_pkg::entry_type entry,
   input  logic                entry_valid,
   output logic                entry_pop,
   input  logic                res_full,
   output logic                res_push,
   output fucg_pkg::rsp_type   res_word
);

   localparam logic signed [24:0] LAST_RO_RESET = -$signed(25'(TRANSFER_BYTES));
   localparam logic signed [25:0] XFER = $signed(26'(TRANSFER_BYTES));

   logic [24:0]        elapsed_ff, elapsed_in;
   logic               written_ff, written_in;
   logic signed [24:0] last_ro_ff, last_ro_in;
   logic signed [24:0] last_rw_ff, last_rw_in;
   logic signed [24:0] prev;
   logic signed [25:0] prev_sum, off_s;
   logic               expired, too_close, rate_ok;

   assign prev      = entry.in_rw_rate ? last_rw_ff : last_ro_ff;
   assign prev_sum  = {prev[24], prev} + XFER;
   assign off_s     = $signed({2'b00, entry.dest_offset});
   assign too_close = (off_s < prev_sum);
   assign expired   = (elapsed_ff > {1'b0, cfg.backoff_ticks});

   // Ticks never wait for room in the result queue.
   assign entry_pop = entry_valid && (entry.is_tick || !res_full);

   always_comb begin
      elapsed_in = elapsed_ff;
      written_in = written_ff;
      last_ro_in = last_ro_ff;
      last_rw_in = last_rw_ff;
      res_push   = 1'b0;
      rate_ok    = 1'b0;
      res_word.status        = entry.pre_status;
      res_word.erase_section = entry.erase_section;
      res_word.mark_header   = 1'b0;
      res_word.write_done    = 1'b0;
      if (entry_pop) begin
         if (entry.is_tick) begin
            if (elapsed_ff != '1) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end else begin
            res_push = 1'b1;
            if (entry.pre_status == fucg_pkg::STATUS_OK) begin
               if (expired) begin
                  last_ro_in = LAST_RO_RESET;
                  rate_ok    = 1'b1;
               end else if (!written_ff) begin
                  rate_ok = !cfg.hard_reset_boot;
               end else begin
                  rate_ok = !too_close;
               end
               if (!rate_ok) begin
                  res_word.status = fucg_pkg::STATUS_RATE;
               end else begin
                  res_word.mark_header = entry.at_base;
                  if (entry.flash_outcome == fucg_pkg::OUTCOME_WRITE_FAIL) begin
                     res_word.status = fucg_pkg::STATUS_WRITE;
                  end else begin
                     elapsed_in = '0;
                     written_in = 1'b1;
                     if (entry.in_rw_rate) begin
                        last_rw_in = $signed({1'b0, entry.dest_offset});
                     end else begin
                        last_ro_in = $signed({1'b0, entry.dest_offset});
                     end
                     res_word.write_done = 1'b1;
                     if (entry.flash_outcome == fucg_pkg::OUTCOME_VERIFY_FAIL) begin
                        res_word.status = fucg_pkg::STATUS_VERIFY;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         written_ff <= 1'b0;
         last_ro_ff <= LAST_RO_RESET;
         last_rw_ff <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         written_ff <= written_in;
         last_ro_ff <= last_ro_in;
         last_rw_ff <= last_rw_in;
      end
   end

endmodule

### sv/flash_update_chunk_guard.sv
// ----------------------------------------------------------------------------
// flash_update_chunk_guard
// Admission guard for firmware-update chunks bound for the inactive flash
// sections, with a decoupled classify front and rate-limit back.
// ----------------------------------------------------------------------------
//  Channel   Ports                         Direction  Moves
//  request   push, full, req_word          in         one tick or chunk word
//  response  pop, empty, rsp_word          out        one result word per chunk
//  config    psel..pready, paddr, pwdata   in/out     register writes and reads
//
// One word is accepted per cycle while full is low. The front classifies it on the way
// into a four-entry queue; the back retires one entry per cycle into a four-entry result
// queue, but holds a chunk while that queue is full. A result passes through both queues
// on its way to the ports. A tick only advances the elapsed counter. Reset is synchronous
// and returns the queues, counters and registers to their reset values. full rises only
// when the result queue is full and the classify queue has filled up behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flash_update_chunk_guard #(
   parameter int HEADER_BYTES   = fucg_pkg::HEADER_BYTES_DEFAULT,
   parameter int TRANSFER_BYTES = fucg_pkg::TRANSFER_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH    = fucg_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH   = fucg_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  fucg_pkg::req_type                   req_word,
   input  logic                                pop,
   output logic                                empty,
   output fucg_pkg::rsp_type                   rsp_word,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fucg_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [fucg_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [fucg_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);

   fucg_pkg::cfg_type   cfg;
   fucg_pkg::entry_type front_entry, back_entry;
   fucg_pkg::rsp_type   res_word;
   logic                entry_empty, entry_pop;
   logic                res_full, res_push;

   fucg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fucg_front #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_front (
      .req   (req_word),
      .cfg   (cfg),
      .entry (front_entry)
   );

   fucg_queue #(
      .WIDTH ($bits(fucg_pkg::entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .full      (full),
      .pop       (entry_pop),
      .pop_data  (back_entry),
      .empty     (entry_empty)
   );

   fucg_back #(
      .TRANSFER_BYTES (TRANSFER_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .entry       (back_entry),
      .entry_valid (!entry_empty),
      .entry_pop   (entry_pop),
      .res_full    (res_full),
      .res_push    (res_push),
      .res_word    (res_word)
   );

   fucg_queue #(
      .WIDTH ($bits(fucg_pkg::rsp_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_word),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_word),
      .empty     (empty)
   );

   `FUCG_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> empty, "result queue not empty after reset")

   `FUCG_ASSERT_RST(a_write_status, clock, reset, (res_push && res_word.write_done) |-> (res_word.status == fucg_pkg::STATUS_OK || res_word.status == fucg_pkg::STATUS_VERIFY), "write recorded with a failing status")

   `FUCG_ASSERT_RST(a_mark_status, clock, reset, (res_push && res_word.mark_header) |-> (res_word.status == fucg_pkg::STATUS_OK || res_word.status == fucg_pkg::STATUS_WRITE || res_word.status == fucg_pkg::STATUS_VERIFY), "header marked before the rate limit passed")

   `FUCG_ASSERT_RST(a_erase_target, clock, reset, (res_push && res_word.status == fucg_pkg::STATUS_ERASE) |-> (res_word.erase_section != fucg_pkg::ERASE_NONE), "erase failure without an erase target")

endmodule

### tb/flash_update_chunk_guard_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flash_update_chunk_guard_test
// Self-checking bench for the update chunk guard. A scoreboard predicts the
// verdict of every accepted chunk word, and tracks the tick counter and the
// per-section offset records. Each popped result word is compared against
// the oldest prediction. Directed words come first, then random sequences
// run under several section layouts and handshake idling mixes.
// ----------------------------------------------------------------------------
module flash_update_chunk_guard_test;
   import fucg_pkg::*;

   localparam int HEADER_LEN    = HEADER_BYTES_DEFAULT;
   localparam int XFER_LEN      = TRANSFER_BYTES_DEFAULT;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_ORDER [6] = '{
      REG_RO_BASE, REG_RO_TOP, REG_RW_BASE, REG_RW_TOP, REG_BACKOFF, REG_HARD_BOOT
   };

   class chunk_verdict_board;
      cfg_type     cfg;
      logic [24:0] elapsed;
      bit          wrote_since_boot;
      int          last_ro_off;
      int          last_rw_off;
      rsp_type     verdicts_due [$];
      int          errors;

      function new();
         cfg = '0;
         cfg.backoff_ticks = BACKOFF_RESET;
         elapsed = '0;
         wrote_since_boot = 1'b0;
         last_ro_off = -XFER_LEN;
         last_rw_off = 0;
         errors = 0;
      endfunction

      task flag_mismatch(input string what);
         errors++;
         if (errors <= 100) begin
            $display("%0t: mismatch: %s", $time, what);
         end
      endtask

      function bit in_header(longint pos, longint base);
         return pos >= base && pos < base + HEADER_LEN;
      endfunction

      // Walks the admission checks in order; the first failing check decides
      // the status. The records move when the chunk is written, and the read-only
      // record is also preset when a chunk reaches the rate check once the backoff has run out.
      function rsp_type admission_verdict(req_type w);
         longint  off;
         longint  fin;
         longint  prev;
         bit      at_base;
         bit      in_rw_rate;
         bit      older;
         rsp_type v;
         off = w.dest_offset;
         fin = off + w.payload_len;
         v = '0;
         v.status = STATUS_OK;
         v.erase_section = ERASE_NONE;
         if (!w.digest_ok) begin
            v.status = STATUS_DATA;
            return v;
         end
         at_base = off == cfg.ro_base || off == cfg.rw_base;
         older = (w.new_epoch != w.old_epoch) ? w.new_epoch < w.old_epoch :
                 (w.new_major != w.old_major) ? w.new_major < w.old_major :
                 w.new_minor < w.old_minor;
         if (at_base) begin
            if (w.payload_len < HEADER_LEN) begin
               v.status = STATUS_TRUNCATED;
               return v;
            end
            if (older) begin
               v.status = STATUS_ROLLBACK;
               return v;
            end
            // Only a read-write header carries a board identity.
            if (off != cfg.ro_base && w.board_reject) begin
               v.status = STATUS_BOARD;
               return v;
            end
         end else if (in_header(off, cfg.ro_base) || in_header(fin, cfg.ro_base) ||
                      in_header(off, cfg.rw_base) || in_header(fin, cfg.rw_base)) begin
            v.status = STATUS_OVERLAP;
            return v;
         end
         if (cfg.rw_top != 0 && off >= cfg.rw_base && fin <= cfg.rw_top) begin
            if (off == cfg.rw_base) begin
               v.erase_section = ERASE_RW;
               if (w.flash_outcome == OUTCOME_ERASE_FAIL) begin
                  v.status = STATUS_ERASE;
                  return v;
               end
            end
         end else if (cfg.ro_top != 0 && off >= cfg.ro_base && fin <= cfg.ro_top) begin
            if (off == cfg.ro_base) begin
               v.erase_section = ERASE_RO;
               if (w.flash_outcome == OUTCOME_ERASE_FAIL) begin
                  v.status = STATUS_ERASE;
                  return v;
               end
            end
         end else begin
            v.status = STATUS_ADDRESS;
            return v;
         end
         in_rw_rate = off >= cfg.rw_base && off < cfg.rw_top;
         if (elapsed > cfg.backoff_ticks) begin
            last_ro_off = -XFER_LEN;
         end else if (!wrote_since_boot) begin
            if (cfg.hard_reset_boot) begin
               v.status = STATUS_RATE;
               return v;
            end
         end else begin
            prev = in_rw_rate ? last_rw_off : last_ro_off;
            if (off < prev + XFER_LEN) begin
               v.status = STATUS_RATE;
               return v;
            end
         end
         v.mark_header = at_base;
         if (w.flash_outcome == OUTCOME_WRITE_FAIL) begin
            v.status = STATUS_WRITE;
            return v;
         end
         elapsed = '0;
         wrote_since_boot = 1'b1;
         if (in_rw_rate) begin
            last_rw_off = int'(off);
         end else begin
            last_ro_off = int'(off);
         end
         v.write_done = 1'b1;
         if (w.flash_outcome == OUTCOME_VERIFY_FAIL) begin
            v.status = STATUS_VERIFY;
         end
         return v;
      endfunction

      function void note_word(req_type w);
         if (w.kind == KIND_TICK) begin
            if (elapsed != '1) begin
               elapsed++;
            end
         end else begin
            verdicts_due.push_back(admission_verdict(w));
         end
      endfunction

      task check_word(input rsp_type got);
         rsp_type want;
         if (verdicts_due.size() == 0) begin
            flag_mismatch($sformatf("result status %0d with nothing expected", got.status));
            return;
         end
         want = verdicts_due.pop_front();
         if (got.status !== want.status || got.erase_section !== want.erase_section ||
             got.mark_header !== want.mark_header || got.write_done !== want.write_done) begin
            flag_mismatch($sformatf(
               "status %0d erase %0d mark %b write %b, expected %0d %0d %b %b",
               got.status, got.erase_section, got.mark_header, got.write_done,
               want.status, want.erase_section, want.mark_header, want.write_done));
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      push;
   logic                      full;
   req_type                   req_word;
   logic                      pop;
   logic                      empty;
   rsp_type                   rsp_word;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int                 send_idle_pct;
   int                 recv_stall_pct;
   longint             ro_next;
   longint             rw_next;
   cfg_type            plan;
   chunk_verdict_board books;

   flash_update_chunk_guard u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

   // Result side: check the word popped at this edge, then decide the next pop.
   initial begin
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            books.check_word(rsp_word);
         end
         pop <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_access(input logic [REG_INDEX_WIDTH-1:0] idx, input logic is_write,
                             input logic [CSR_DATA_WIDTH-1:0] wdata,
                             output logic [CSR_DATA_WIDTH-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic load_settings(input cfg_type c);
      logic [CSR_DATA_WIDTH-1:0] vals [6];
      logic [CSR_DATA_WIDTH-1:0] got;
      logic [REG_INDEX_WIDTH-1:0] idx;
      int k;
      vals[REG_RO_BASE]   = 32'(c.ro_base);
      vals[REG_RO_TOP]    = 32'(c.ro_top);
      vals[REG_RW_BASE]   = 32'(c.rw_base);
      vals[REG_RW_TOP]    = 32'(c.rw_top);
      vals[REG_BACKOFF]   = 32'(c.backoff_ticks);
      vals[REG_HARD_BOOT] = 32'(c.hard_reset_boot);
      for (k = 0; k < 6; k++) begin
         idx = REG_ORDER[k];
         csr_access(idx, 1'b1, vals[idx], got);
      end
      for (k = 0; k < 6; k++) begin
         idx = REG_ORDER[k];
         csr_access(idx, 1'b0, '0, got);
         if (got !== vals[idx]) begin
            books.flag_mismatch($sformatf("register %0d reads %h, written %h",
                                          idx, got, vals[idx]));
         end
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      books.cfg = c;
   endtask

   // push is left high after an accepted word so back-to-back words need no
   // second assignment in the same step.
   task automatic send_word(input req_type w);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full);
      books.note_word(w);
   endtask

   task automatic wait_settled();
      push <= 1'b0;
      while (books.verdicts_due.size() != 0) @(posedge clock);
      // Ticks give no result but may still be in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_type chunk_at(input logic [23:0] off, input logic [15:0] size);
      req_type w;
      w.kind              = KIND_CHUNK;
      w.dest_offset       = off;
      w.payload_len       = size;
      w.digest_ok         = 1'b1;
      w.old_epoch         = $urandom;
      w.old_major         = $urandom;
      w.old_minor         = $urandom;
      w.new_epoch         = w.old_epoch;
      w.new_major         = w.old_major;
      w.new_minor         = w.old_minor;
      w.board_reject      = 1'b0;
      w.flash_outcome     = OUTCOME_OK;
      return w;
   endfunction

   task automatic run_random(input int count);
      req_type w;
      int      pick;
      int      lvl;
      int      k;
      bit      use_rw;
      longint  base;
      longint  top;
      longint  off;
      longint  nxt;
      for (k = 0; k < count; k++) begin
         pick   = $urandom_range(99);
         use_rw = $urandom_range(1);
         base   = use_rw ? plan.rw_base : plan.ro_base;
         top    = use_rw ? plan.rw_top : plan.ro_top;
         w.kind              = KIND_CHUNK;
         w.dest_offset       = 24'($urandom);
         w.payload_len       = 16'($urandom);
         w.digest_ok         = $urandom_range(99) < 95;
         w.board_reject      = $urandom_range(99) < 10;
         w.flash_outcome     = ($urandom_range(99) < 70) ? OUTCOME_OK : 2'($urandom_range(3));
         w.old_epoch = $urandom;
         w.old_major = $urandom;
         w.old_minor = $urandom;
         w.new_epoch = $urandom;
         w.new_major = $urandom;
         w.new_minor = $urandom;
         // The version level that decides is mostly made to not go backwards.
         lvl = $urandom_range(3);
         if (lvl >= 1) w.new_epoch = w.old_epoch;
         if (lvl >= 2) w.new_major = w.old_major;
         if (lvl == 3) w.new_minor = w.old_minor;
         if ($urandom_range(99) < 85) begin
            if (lvl == 0 && w.new_epoch < w.old_epoch)
               {w.new_epoch, w.old_epoch} = {w.old_epoch, w.new_epoch};
            if (lvl == 1 && w.new_major < w.old_major)
               {w.new_major, w.old_major} = {w.old_major, w.new_major};
            if (lvl == 2 && w.new_minor < w.old_minor)
               {w.new_minor, w.old_minor} = {w.old_minor, w.new_minor};
         end
         if (pick < 25) begin
            w.kind = KIND_TICK;
         end else if (pick < 40) begin
            // A header word restarts the section's sequence.
            w.dest_offset = 24'(base);
            w.payload_len = ($urandom_range(99) < 70) ? 16'(HEADER_LEN) :
                            16'($urandom_range(65535, HEADER_LEN - 8));
            if (use_rw) rw_next = base + HEADER_LEN;
            else ro_next = base + HEADER_LEN;
         end else if (pick < 85) begin
            off = use_rw ? rw_next : ro_next;
            if ($urandom_range(99) < 10 && off >= XFER_LEN) off -= XFER_LEN;
            w.dest_offset = 24'(off);
            w.payload_len = 16'($urandom_range(XFER_LEN, 1));
            nxt = off + XFER_LEN;
            if (nxt + XFER_LEN > top) nxt = base + HEADER_LEN;
            if (use_rw) rw_next = nxt;
            else ro_next = nxt;
         end else if (pick < 92) begin
            w.dest_offset = 24'(base + $urandom_range(2 * HEADER_LEN) - HEADER_LEN);
            w.payload_len = 16'($urandom_range(2 * HEADER_LEN));
         end
         send_word(w);
      end
   endtask

   initial begin
      req_type w;
      int      ph;
      reset          = 1'b1;
      push           = 1'b0;
      req_word       = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      ro_next        = 0;
      rw_next        = 0;
      books = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any write, a soft boot lets a header through the rate limit;
      // the write failure keeps the no-write state for the hard boot case.
      plan = '{ro_base: 24'h010000, ro_top: 24'h020000, rw_base: 24'h040000,
               rw_top: 24'h050000, backoff_ticks: 24'hFFFFFF, hard_reset_boot: 1'b0};
      load_settings(plan);
      w = chunk_at(plan.ro_base, 16'(HEADER_LEN));
      w.flash_outcome = OUTCOME_WRITE_FAIL;
      send_word(w);
      wait_settled();

      plan.backoff_ticks = 24'd2;
      plan.hard_reset_boot = 1'b1;
      load_settings(plan);
      send_word(chunk_at(plan.ro_base, 16'(HEADER_LEN)));
      repeat (3) begin
         w = chunk_at(24'($urandom), 16'($urandom));
         w.kind = KIND_TICK;
         send_word(w);
      end
      send_word(chunk_at(plan.ro_base, 16'(HEADER_LEN)));
      send_word(chunk_at(plan.ro_base + 24'(XFER_LEN), 16'(XFER_LEN)));
      send_word(chunk_at(plan.ro_base + 24'(XFER_LEN), 16'd512));
      w = chunk_at(plan.ro_base + 24'h2000, 16'd256);
      w.digest_ok = 1'b0;
      send_word(w);
      send_word(chunk_at(plan.ro_base + 24'd16, 16'd64));
      send_word(chunk_at(plan.ro_base - 24'd100, 16'd200));
      send_word(chunk_at(plan.ro_base, 16'(HEADER_LEN - 1)));
      w = chunk_at(plan.ro_base, 16'd2048);
      w.old_epoch = 32'd5;
      w.new_epoch = 32'd4;
      send_word(w);
      w = chunk_at(plan.ro_base, 16'd2048);
      w.old_major = 32'd7;
      w.new_major = 32'd3;
      send_word(w);
      w = chunk_at(plan.ro_base, 16'd2048);
      w.old_minor = 32'hFFFFFFFF;
      w.new_minor = 32'd0;
      send_word(w);
      w = chunk_at(plan.rw_base, 16'(HEADER_LEN));
      w.board_reject = 1'b1;
      send_word(w);
      w = chunk_at(plan.rw_base, 16'(HEADER_LEN));
      w.flash_outcome = OUTCOME_ERASE_FAIL;
      send_word(w);
      // An erase failure on a word that needs no erase is treated as success.
      w = chunk_at(plan.rw_base + 24'h1000, 16'd256);
      w.flash_outcome = OUTCOME_ERASE_FAIL;
      send_word(w);
      w = chunk_at(plan.rw_base + 24'h2000, 16'd256);
      w.flash_outcome = OUTCOME_VERIFY_FAIL;
      send_word(w);
      send_word(chunk_at(plan.rw_top - 24'd256, 16'd256));
      send_word(chunk_at(plan.rw_top - 24'd255, 16'd256));
      send_word(chunk_at(24'd0, 16'd0));
      w = chunk_at(24'hFFFFFF, 16'hFFFF);
      w.new_epoch = '1;
      w.new_major = '1;
      w.new_minor = '1;
      w.old_epoch = '1;
      w.old_major = '1;
      w.old_minor = '1;
      w.board_reject = 1'b1;
      w.flash_outcome = OUTCOME_VERIFY_FAIL;
      send_word(w);
      wait_settled();

      for (ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         case (ph)
            0: plan = '{ro_base: 24'h000000, ro_top: 24'h008000, rw_base: 24'h010000,
                        rw_top: 24'h018000, backoff_ticks: 24'd3, hard_reset_boot: 1'b1};
            1: plan = '{ro_base: 24'h100000, ro_top: 24'h104000, rw_base: 24'hFF0000,
                        rw_top: 24'hFFFFFF, backoff_ticks: 24'd0, hard_reset_boot: 1'b0};
            // Read-only section disabled and the largest backoff the register holds.
            2: plan = '{ro_base: 24'h200000, ro_top: 24'h000000, rw_base: 24'h300000,
                        rw_top: 24'h308000, backoff_ticks: 24'hFFFFFF, hard_reset_boot: 1'b1};
            3: plan = '{ro_base: 24'h400000, ro_top: 24'h408000, rw_base: 24'h500000,
                        rw_top: 24'h000000, backoff_ticks: 24'($urandom_range(6, 1)),
                        hard_reset_boot: 1'b0};
            // Shared base: header erases the read-write section, skips the board check.
            4: plan = '{ro_base: 24'h600000, ro_top: 24'h608000, rw_base: 24'h600000,
                        rw_top: 24'h604000, backoff_ticks: 24'd2, hard_reset_boot: 1'b1};
            default: begin
               plan.ro_base = 24'($urandom);
               plan.ro_top = 24'(plan.ro_base + $urandom_range(32'h10000));
               plan.rw_base = 24'($urandom);
               plan.rw_top = 24'(plan.rw_base + $urandom_range(32'h10000));
               plan.backoff_ticks = 24'($urandom_range(8));
               plan.hard_reset_boot = 1'($urandom_range(1));
            end
         endcase
         load_settings(plan);
         ro_next = plan.ro_base + HEADER_LEN;
         rw_next = plan.rw_base + HEADER_LEN;
         if (ph == 2) begin
            run_random(40);
            wait_settled();
            run_random(35);
         end else begin
            run_random(75);
         end
         wait_settled();
      end

      repeat (10) @(posedge clock);
      if (books.errors == 0 && books.verdicts_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
